[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
// ASSERT_ALWAYS: clocked property, disabled during reset.
// ASSERT_NEVER: the given condition is never true at a clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

[rtl/tss_pkg.sv]
package tss_pkg;

    // field and datapath widths
    localparam int T_W    = 16;
    localparam int H_W    = 17;
    localparam int K_W    = 24;
    localparam int PIV_W  = 26;
    localparam int RHS_W  = 40;
    localparam int Y_W    = 18;
    localparam int OUT_W  = 19;
    localparam int PIDX_W = 6;
    localparam int NUM_W  = 64;
    localparam int DEN_W  = PIV_W;
    localparam int DCNT_W = 6;

    localparam logic [RHS_W-1:0] RHS_CAP   = {RHS_W{1'b1}};
    localparam logic [Y_W-1:0]   Y_CAP     = {Y_W{1'b1}};
    localparam logic [T_W-1:0]   T_DEFAULT = 16'd400;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_LOAD,
        S_SUB_GO,
        S_SUB_WAIT,
        S_ADD_GO,
        S_ADD_WAIT,
        S_WRITE,
        S_BRD,
        S_BLOAD,
        S_BGO,
        S_BWAIT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
    } div_rsp_t;

endpackage

[rtl/tss_channels.sv]
interface tss_in_if;
    logic                     valid;
    logic                     ready;
    logic [tss_pkg::H_W-1:0]  h_value;
    logic [tss_pkg::K_W-1:0]  weight;
    logic                     last_point;
    modport source (output valid, h_value, weight, last_point, input ready);
    modport sink   (input valid, h_value, weight, last_point, output ready);
endinterface

interface tss_out_if;
    logic                        valid;
    logic                        ready;
    logic [tss_pkg::OUT_W-1:0]   smoothed;
    logic [tss_pkg::PIDX_W-1:0]  point_index;
    logic                        pivot_error;
    logic                        last_result;
    modport source (output valid, smoothed, point_index, pivot_error, last_result,
                    input ready);
    modport sink   (input valid, smoothed, point_index, pivot_error, last_result,
                    output ready);
endinterface

interface tss_cfg_if;
    logic                    valid;
    logic                    ready;
    logic [tss_pkg::T_W-1:0] tension;
    modport source (output valid, tension, input ready);
    modport sink   (input valid, tension, output ready);
endinterface

[rtl/tss_div.sv]
module tss_div (
    input  logic              clk,
    input  logic              rst_n,
    input  tss_pkg::div_req_t req,
    output tss_pkg::div_rsp_t rsp
);
    import tss_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              dzero_reg, dzero_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [DEN_W:0]    trial;
    logic              ge;

    // one quotient bit a cycle, numerator shifts out of the top of quo_reg
    always_comb
    begin
        trial      = {rem_reg, quo_reg[NUM_W-1]};
        ge         = (trial >= {1'b0, den_reg});
        busy_next  = busy_reg;
        done_next  = 1'b0;
        dzero_next = dzero_reg;
        cnt_next   = cnt_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            dzero_next = (req.den == '0);
            cnt_next   = '0;
            den_next   = req.den;
            rem_next   = '0;
            quo_next   = req.num;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == {DCNT_W{1'b1}})
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dzero_reg <= dzero_next;
        cnt_reg   <= cnt_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
    end

    // a zero divisor gives a zero quotient
    assign rsp.done = done_reg;
    assign rsp.quo  = dzero_reg ? '0 : quo_reg;

endmodule

[rtl/tridiagonal_smoothing_solver.sv]
// Channel   Dir  Payload                                              Beat when
// cfg       in   tension                                              valid & ready
// points    in   h_value, weight, last_point                          valid & ready
// results   out  smoothed, point_index, pivot_error, last_result      valid & ready
//
// Each point after the first makes two 64-step passes of the shared
// radix-2 divider (pivot update, right-hand side update), plus memory access.
// The first point of a run needs no division.
// After the last point each result takes one divider pass
// plus however long the result beat is stalled; points and tension are refused meanwhile.
// Reset clears the sequencer, point count and error flag; tension returns to 400.
`include "assert_macros.svh"

module tridiagonal_smoothing_solver #(
    parameter int MAX_POINTS = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    tss_cfg_if.sink   cfg,
    tss_in_if.sink    points,
    tss_out_if.source results
);
    import tss_pkg::*;

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int ENT_W = PIV_W + RHS_W;
    localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(MAX_POINTS - 1);

    state_t             state_reg, state_next;
    logic [T_W-1:0]     tension_reg;
    logic [IDX_W-1:0]   cnt_reg, cnt_next;
    logic               err_reg, err_next;
    logic [IDX_W-1:0]   i_reg, i_next;
    logic               first_reg, first_next;
    logic [H_W-1:0]     h_reg, h_next;
    logic [K_W-1:0]     k_reg, k_next;
    logic               last_reg, last_next;
    logic [PIV_W-1:0]   piv_reg, piv_next;
    logic [RHS_W-1:0]   rhs_reg, rhs_next;
    logic [2*T_W-1:0]   tt_reg, tt_next;
    logic [T_W+RHS_W-1:0] tpr_reg, tpr_next;
    logic [PIV_W-1:0]   pp_reg, pp_next;
    logic [Y_W-1:0]     y_reg, y_next;
    logic [T_W+Y_W-1:0] ty_reg, ty_next;
    logic [RHS_W:0]     bnum_reg, bnum_next;

    logic [ENT_W-1:0]   store [MAX_POINTS];
    logic [ENT_W-1:0]   rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               rd_en;
    logic               wr_en;
    logic [PIV_W-1:0]   rd_piv;
    logic [RHS_W-1:0]   rd_rhs;

    logic [H_W+K_W-1:0] kh;
    logic [RHS_W:0]     rsum;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    logic               div_wait;
    logic               final_beat;
    logic               full_write;

    assign rd_piv = rd_data_reg[ENT_W-1:RHS_W];
    assign rd_rhs = rd_data_reg[RHS_W-1:0];
    assign kh     = h_reg * k_reg;
    assign rsum   = {1'b0, rhs_reg} + {1'b0, div_rsp.quo[RHS_W-1:0]};

    tss_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // configuration register, written only between points
    assign cfg.ready = (state_reg == S_IDLE);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tension_reg <= T_DEFAULT;
        else if (cfg.valid && cfg.ready)
            tension_reg <= cfg.tension;
    end

    // sequencer: next state and datapath updates
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        err_next   = err_reg;
        i_next     = i_reg;
        first_next = first_reg;
        h_next     = h_reg;
        k_next     = k_reg;
        last_next  = last_reg;
        piv_next   = piv_reg;
        rhs_next   = rhs_reg;
        tt_next    = tt_reg;
        tpr_next   = tpr_reg;
        pp_next    = pp_reg;
        y_next     = y_reg;
        ty_next    = ty_reg;
        bnum_next  = bnum_reg;
        rd_en      = 1'b0;
        rd_addr    = i_reg;
        wr_en      = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = NUM_W'({tt_reg, 16'b0});
        div_req.den   = pp_reg;
        points.ready  = 1'b0;
        results.valid = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                points.ready = 1'b1;
                if (points.valid)
                begin
                    h_next     = points.h_value;
                    k_next     = points.weight;
                    last_next  = points.last_point | (cnt_reg == IDX_TOP);
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                piv_next = PIV_W'(k_reg) + PIV_W'({tension_reg, 9'b0});
                rhs_next = RHS_W'(kh[H_W+K_W-1:8])
                         + (last_reg ? RHS_W'({tension_reg, 16'b0}) : '0);
                tt_next  = tension_reg * tension_reg;
                rd_en    = 1'b1;
                rd_addr  = cnt_reg - 1'b1;
                state_next = (cnt_reg == '0) ? S_WRITE : S_LOAD;
            end
            S_LOAD:
            begin
                pp_next    = rd_piv;
                tpr_next   = tension_reg * rd_rhs;
                state_next = S_SUB_GO;
            end
            S_SUB_GO:
            begin
                div_req.start = 1'b1;
                state_next    = S_SUB_WAIT;
            end
            S_SUB_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if ((div_rsp.quo[NUM_W-1:PIV_W] != '0) ||
                        (div_rsp.quo[PIV_W-1:0] > piv_reg))
                        piv_next = '0;
                    else
                        piv_next = piv_reg - div_rsp.quo[PIV_W-1:0];
                    state_next = S_ADD_GO;
                end
            end
            S_ADD_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = {tpr_reg, 8'b0};
                state_next    = S_ADD_WAIT;
            end
            S_ADD_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if ((div_rsp.quo[NUM_W-1:RHS_W] != '0) || rsum[RHS_W])
                        rhs_next = RHS_CAP;
                    else
                        rhs_next = rsum[RHS_W-1:0];
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                wr_en    = 1'b1;
                err_next = err_reg | (piv_reg == '0);
                if (last_reg)
                begin
                    i_next     = cnt_reg;
                    first_next = 1'b1;
                    state_next = S_BRD;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_BRD:
            begin
                rd_en      = 1'b1;
                ty_next    = tension_reg * y_reg;
                state_next = S_BLOAD;
            end
            S_BLOAD:
            begin
                pp_next    = rd_piv;
                bnum_next  = {1'b0, rd_rhs} + (first_reg ? '0 : (RHS_W+1)'(ty_reg));
                state_next = S_BGO;
            end
            S_BGO:
            begin
                div_req.start = 1'b1;
                div_req.num   = NUM_W'({bnum_reg, 8'b0});
                state_next    = S_BWAIT;
            end
            S_BWAIT:
            begin
                if (div_rsp.done)
                begin
                    y_next = (div_rsp.quo[NUM_W-1:Y_W] != '0) ? Y_CAP
                                                              : div_rsp.quo[Y_W-1:0];
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                results.valid = 1'b1;
                if (results.ready)
                begin
                    first_next = 1'b0;
                    if (i_reg == '0)
                    begin
                        cnt_next   = '0;
                        err_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg - 1'b1;
                        state_next = S_BRD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result beat payload
    assign results.smoothed    = {1'b0, y_reg};
    assign results.point_index = PIDX_W'(i_reg);
    assign results.pivot_error = err_reg;
    assign results.last_result = (i_reg == '0);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            err_reg   <= 1'b0;
            first_reg <= 1'b0;
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            err_reg   <= err_next;
            first_reg <= first_next;
            i_reg     <= i_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        h_reg    <= h_next;
        k_reg    <= k_next;
        last_reg <= last_next;
        piv_reg  <= piv_next;
        rhs_reg  <= rhs_next;
        tt_reg   <= tt_next;
        tpr_reg  <= tpr_next;
        pp_reg   <= pp_next;
        y_reg    <= y_next;
        ty_reg   <= ty_next;
        bnum_reg <= bnum_next;
    end

    // pivot / right-hand side store, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store[cnt_reg] <= {piv_reg, rhs_reg};
        if (rd_en)
            rd_data_reg <= store[rd_addr];
    end

    // terms for the checks below
    assign div_wait   = (state_reg == S_SUB_WAIT) || (state_reg == S_ADD_WAIT)
                     || (state_reg == S_BWAIT);
    assign final_beat = results.valid && results.ready && results.last_result;
    assign full_write = (state_reg == S_WRITE) && (cnt_reg == IDX_TOP);

    `ASSERT_NEVER(a_no_overlap, clk, rst_n, points.ready && results.valid, "both sides open")
    `ASSERT_ALWAYS(a_done_expected, clk, rst_n, div_rsp.done |-> div_wait, "stray divider done")
    `ASSERT_ALWAYS(a_run_ends, clk, rst_n, final_beat |=> cnt_reg == '0 && !err_reg, "stale run")
    `ASSERT_ALWAYS(a_full_ends, clk, rst_n, full_write |-> last_reg, "full store left open")

endmodule

[test/tss_checker.sv]
module tss_checker (
    input  logic      clk,
    input  logic      rst_n,
    tss_cfg_if        cfg,
    tss_in_if         points,
    tss_out_if        results,
    output int        fail_count,
    output int        pending_count,
    output int        result_count
);
    import tss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam longint unsigned RHS_LIMIT = (64'd1 << 40) - 64'd1;
    localparam longint unsigned Y_LIMIT   = 64'd262143;

    typedef struct {
        logic [OUT_W-1:0]  smoothed;
        logic [PIDX_W-1:0] point_index;
        logic              pivot_error;
        logic              last_result;
    } smooth_beat_t;

    // solver state mirrored in the checker
    longint unsigned pivots [DEPTH];
    longint unsigned rhs_vals [DEPTH];
    int unsigned     loaded;
    logic            zero_pivot_seen;
    logic [T_W-1:0]  cur_tension;
    smooth_beat_t    smooth_queue [$];

    function automatic longint unsigned safe_div(longint unsigned n, longint unsigned d);
        return (d == 0) ? 64'd0 : n / d;
    endfunction

    // forward sweep for one point; back substitution on the last one
    task automatic sweep_point(logic [H_W-1:0] h, logic [K_W-1:0] k, logic last_in);
        longint unsigned t, piv, rhs, sub, add, y, num;
        int unsigned     idx;
        logic            last;
        smooth_beat_t    b;
        t    = cur_tension;
        idx  = loaded;
        last = last_in;
        if (idx >= DEPTH)
            idx = DEPTH - 1;
        if (idx == DEPTH - 1)
            last = 1'b1;
        piv = longint'(k) + t * 512;
        rhs = (longint'(k) * longint'(h)) >> 8;
        if (last)
            rhs += t << 16;
        if (idx > 0)
        begin
            sub = safe_div((t * t) << 16, pivots[idx-1]);
            add = safe_div(t * rhs_vals[idx-1] * 256, pivots[idx-1]);
            piv = (sub > piv) ? 64'd0 : piv - sub;
            if (add > RHS_LIMIT - rhs)
                rhs = RHS_LIMIT;
            else
                rhs += add;
        end
        if (rhs > RHS_LIMIT)
            rhs = RHS_LIMIT;
        if (piv == 0)
            zero_pivot_seen = 1'b1;
        pivots[idx]   = piv;
        rhs_vals[idx] = rhs;
        if (!last)
        begin
            loaded = idx + 1;
            return;
        end
        y = 0;
        for (int i = idx; i >= 0; i--)
        begin
            num = rhs_vals[i];
            if (i != idx)
                num += t * y;
            y = safe_div(num << 8, pivots[i]);
            if (y > Y_LIMIT)
                y = Y_LIMIT;
            b.smoothed    = y[OUT_W-1:0];
            b.point_index = i[PIDX_W-1:0];
            b.pivot_error = zero_pivot_seen;
            b.last_result = (i == 0);
            smooth_queue = {smooth_queue, b};
        end
        loaded          = 0;
        zero_pivot_seen = 1'b0;
    endtask

    assign pending_count = smooth_queue.size();

    initial
    begin
        fail_count      = 0;
        result_count    = 0;
        loaded          = 0;
        zero_pivot_seen = 1'b0;
        cur_tension     = T_DEFAULT;
    end

    // beats sampled at the rising edge
    always @(posedge clk)
    begin
        smooth_beat_t e;
        if (rst_n)
        begin
            if (cfg.valid && cfg.ready)
                cur_tension = cfg.tension;
            if (points.valid && points.ready)
                sweep_point(points.h_value, points.weight, points.last_point);
            if (results.valid && results.ready)
            begin
                result_count++;
                if (smooth_queue.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result beat: smoothed %0d index %0d",
                             $time, results.smoothed, results.point_index);
                end
                else
                begin
                    e = smooth_queue.pop_front();
                    if (results.smoothed !== e.smoothed)
                    begin
                        fail_count++;
                        $display("%0t: smoothed expected %0d actual %0d (index %0d)",
                                 $time, e.smoothed, results.smoothed, e.point_index);
                    end
                    if (results.point_index !== e.point_index)
                    begin
                        fail_count++;
                        $display("%0t: point_index expected %0d actual %0d",
                                 $time, e.point_index, results.point_index);
                    end
                    if (results.pivot_error !== e.pivot_error)
                    begin
                        fail_count++;
                        $display("%0t: pivot_error expected %0b actual %0b",
                                 $time, e.pivot_error, results.pivot_error);
                    end
                    if (results.last_result !== e.last_result)
                    begin
                        fail_count++;
                        $display("%0t: last_result expected %0b actual %0b",
                                 $time, e.last_result, results.last_result);
                    end
                end
            end
        end
    end

endmodule

[test/tb_tridiagonal_smoothing_solver.sv]
module tb_tridiagonal_smoothing_solver;
    import tss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  ITEM_TARGET = 270;
    localparam int  CYCLE_LIMIT = 600000;
    localparam int  DRAIN_WAIT  = 200;

    logic clk;
    logic rst_n;
    int   fail_count, pending_count, result_count;
    int   point_count_sent, set_count, cycles;
    int   set_len;
    bit   burst;
    bit   result_beat;
    int   stall_left;

    tss_cfg_if cfg_if ();
    tss_in_if  pts_if ();
    tss_out_if res_if ();

    tridiagonal_smoothing_solver #(.MAX_POINTS(64)) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_if),
        .points  (pts_if),
        .results (res_if)
    );

    tss_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_if),
        .points        (pts_if),
        .results       (res_if),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .result_count  (result_count)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side back-pressure: fresh stall drawn after each beat
    always @(posedge clk)
        result_beat = res_if.valid && res_if.ready;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (result_beat)
                stall_left = burst ? 0 : $urandom_range(0, 5);
            if (stall_left > 0)
            begin
                res_if.ready <= 1'b0;
                stall_left--;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    task automatic write_tension(logic [T_W-1:0] v);
        cfg_if.tension = v;
        cfg_if.valid   = 1'b1;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // one point beat; valid stays up when the next gap is zero
    task automatic send_point(logic [H_W-1:0] h, logic [K_W-1:0] k, logic last);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            pts_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pts_if.h_value    = h;
        pts_if.weight     = k;
        pts_if.last_point = last;
        pts_if.valid      = 1'b1;
        @(posedge clk);
        while (!pts_if.ready)
            @(posedge clk);
        @(negedge clk);
        point_count_sent++;
    endtask

    task automatic wait_idle();
        pts_if.valid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    function automatic logic [K_W-1:0] pick_weight();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return {K_W{1'b1}};
            2:       return K_W'($urandom_range(0, 1023));
            default: return K_W'($urandom());
        endcase
    endfunction

    function automatic logic [T_W-1:0] pick_tension();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return {T_W{1'b1}};
            2:       return T_DEFAULT;
            3:       return T_W'($urandom_range(1, 64));
            default: return T_W'($urandom());
        endcase
    endfunction

    // a data set of n random points; the full-store case sends no end mark
    task automatic send_set(int n, bit mark_end);
        for (int i = 0; i < n; i++)
            send_point(H_W'($urandom()), pick_weight(), mark_end && (i == n - 1));
        set_count++;
        wait_idle();
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cycles            = 0;
        point_count_sent  = 0;
        set_count         = 0;
        set_len           = 0;
        burst             = 1'b0;
        stall_left        = 0;
        result_beat       = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.tension    = '0;
        pts_if.valid      = 1'b0;
        pts_if.h_value    = '0;
        pts_if.weight     = '0;
        pts_if.last_point = 1'b0;
        res_if.ready      = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // directed: reset tension, field extremes, single-point set
        send_point({H_W{1'b1}}, {K_W{1'b1}}, 1'b1);
        wait_idle();
        send_point('0, '0, 1'b0);
        send_point({H_W{1'b1}}, '0, 1'b1);
        wait_idle();
        // zero tension with zero weights: zero pivot chain
        write_tension('0);
        send_point({H_W{1'b1}}, '0, 1'b0);
        send_point('0, '0, 1'b0);
        send_point({H_W{1'b1}}, 24'd256, 1'b1);
        wait_idle();
        send_point(17'h10000, 24'd256, 1'b0);
        send_point(17'h0ffff, 24'd1, 1'b1);
        wait_idle();
        // maximum tension, saturation of rhs and output
        write_tension({T_W{1'b1}});
        send_point({H_W{1'b1}}, {K_W{1'b1}}, 1'b0);
        send_point({H_W{1'b1}}, {K_W{1'b1}}, 1'b0);
        send_point('0, '0, 1'b0);
        send_point({H_W{1'b1}}, {K_W{1'b1}}, 1'b1);
        wait_idle();
        write_tension(16'd1);
        send_point({H_W{1'b1}}, 24'd0, 1'b0);
        send_point({H_W{1'b1}}, {K_W{1'b1}}, 1'b1);
        wait_idle();
        set_count += 6;

        // store full: 64 points with no end mark
        write_tension(pick_tension());
        send_set(64, 1'b0);

        // random sets, mostly short, trimmed to the point budget
        while (point_count_sent < ITEM_TARGET)
        begin
            burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0)
                write_tension(pick_tension());
            if ($urandom_range(0, 19) == 0)
                set_len = $urandom_range(9, 64);
            else
                set_len = $urandom_range(1, 8);
            if (set_len > ITEM_TARGET - point_count_sent)
                set_len = ITEM_TARGET - point_count_sent;
            send_set(set_len, 1'b1);
        end
        burst = 1'b0;
        wait_idle();

        $display("Sent %0d points in %0d data sets, checked %0d smoothed values.",
                 point_count_sent, set_count, result_count);
        $display("Tension covered zero, maximum, default and random settings.");
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
